### rtl/kvl_pkg.sv
// Shared types and constants of the keyframe vec3 interpolation core.
// Used by kvl_ctrl, kvl_dpath and keyframe_vec3_lerp_core; depends on nothing.
package kvl_pkg;

    // Default table depth
    localparam int DEF_MAX_KEYS = 64;

    // Factor format: unsigned Q1.16, one is 1 << 16
    localparam int FW = 17;
    localparam logic [FW-1:0] F_ONE  = 17'h10000;
    localparam logic [FW-1:0] F_ZERO = 17'h00000;
    localparam int DIV_STEPS = 16;

    // Input function codes
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // Table read address sources
    localparam logic [1:0] ADDR_SCAN = 2'd0;
    localparam logic [1:0] ADDR_I    = 2'd1;
    localparam logic [1:0] ADDR_J    = 2'd2;

    // Vector components
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    // Register index of key_count (word address bit)
    localparam logic REG_KEY_COUNT = 1'b0;

    // Controller to datapath commands
    typedef struct packed {
        logic       mem_we;     // write a load item into the table
        logic       start;      // latch sample time, clear scan
        logic [1:0] addr_sel;   // table read address source
        logic       scan_step;  // advance scan index
        logic       take_i;     // start key is the current scan index
        logic       lat_a;      // latch start key
        logic       lat_b;      // latch end key, form num and gap
        logic       f_set;      // decide factor or arm divider
        logic       div_step;   // one quotient bit
        logic       mul;        // multiply one component
        logic       acc;        // add step to start value
        logic [1:0] comp;       // component in work
        logic       out_load;   // move result to output register
    } t_kvl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic one_key;
        logic scan_hit;
        logic scan_last;
        logic need_div;
        logic out_free;
    } t_kvl_sts;

endpackage

### rtl/kvl_ctrl.sv
// Sequencer of the keyframe interpolation core: scan, fetch, divide, multiply.
// Depends on kvl_pkg; drives kvl_dpath through t_kvl_cmd.
module kvl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_func,
    input  kvl_pkg::t_kvl_sts i_sts,
    output kvl_pkg::t_kvl_cmd o_cmd,
    output logic              o_in_stall
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_CMP = 4'd2;
    localparam logic [3:0] S_A_RD     = 4'd3;
    localparam logic [3:0] S_A_LAT    = 4'd4;
    localparam logic [3:0] S_B_LAT    = 4'd5;
    localparam logic [3:0] S_FSET     = 4'd6;
    localparam logic [3:0] S_DIV      = 4'd7;
    localparam logic [3:0] S_MUL      = 4'd8;
    localparam logic [3:0] S_ACC      = 4'd9;
    localparam logic [3:0] S_PUT      = 4'd10;

    localparam int CW = $clog2(kvl_pkg::DIV_STEPS);

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [1:0]    r_comp, n_comp;
    logic          accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_comp  = r_comp;
        o_cmd   = '0;
        o_cmd.comp = r_comp;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_func == kvl_pkg::FUNC_LOAD) begin
                        o_cmd.mem_we = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state = i_sts.one_key ? S_A_RD : S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                o_cmd.addr_sel = kvl_pkg::ADDR_SCAN;
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (i_sts.scan_hit) begin
                    o_cmd.take_i = 1'b1;
                    n_state = S_A_RD;
                end else if (i_sts.scan_last) begin
                    n_state = S_A_RD;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_A_RD: begin
                o_cmd.addr_sel = kvl_pkg::ADDR_I;
                n_state = S_A_LAT;
            end
            S_A_LAT: begin
                o_cmd.lat_a    = 1'b1;
                o_cmd.addr_sel = kvl_pkg::ADDR_J;
                n_state = S_B_LAT;
            end
            S_B_LAT: begin
                o_cmd.lat_b = 1'b1;
                n_state = S_FSET;
            end
            S_FSET: begin
                o_cmd.f_set = 1'b1;
                n_cnt  = '0;
                n_comp = kvl_pkg::COMP_X;
                n_state = i_sts.need_div ? S_DIV : S_MUL;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(kvl_pkg::DIV_STEPS - 1)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (r_comp == kvl_pkg::COMP_Z) begin
                    n_state = S_PUT;
                end else begin
                    n_comp  = r_comp + 1'b1;
                    n_state = S_MUL;
                end
            end
            S_PUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_comp  <= kvl_pkg::COMP_X;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_comp  <= n_comp;
        end
    end

endmodule

### rtl/kvl_dpath.sv
// Datapath of the keyframe interpolation core: key tables, scan compare,
// serial factor divider, shared multiplier and output register. Depends on kvl_pkg.
module kvl_dpath #(
    parameter int MAX_KEYS = kvl_pkg::DEF_MAX_KEYS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kvl_pkg::t_kvl_cmd  i_cmd,
    output kvl_pkg::t_kvl_sts  o_sts,
    input  logic [6:0]         i_key_count,
    input  logic [5:0]         i_key_index,
    input  logic [31:0]        i_key_time,
    input  logic signed [31:0] i_key_x,
    input  logic signed [31:0] i_key_y,
    input  logic signed [31:0] i_key_z,
    input  logic [31:0]        i_sample_time,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int NW = $clog2(MAX_KEYS + 1);
    localparam int FW = kvl_pkg::FW;
    localparam int QW = kvl_pkg::DIV_STEPS;

    // Key tables
    logic [31:0] mem_t [MAX_KEYS];
    logic [31:0] mem_x [MAX_KEYS];
    logic [31:0] mem_y [MAX_KEYS];
    logic [31:0] mem_z [MAX_KEYS];

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_ok;
    logic [31:0]   r_rd_t, r_rd_x, r_rd_y, r_rd_z;

    logic [AW-1:0] r_k, r_i;
    logic [31:0]   r_t;
    logic [NW-1:0] n_keys;
    logic [NW:0]   k_plus2;

    logic [31:0]        r_a_t;
    logic signed [31:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz;
    logic signed [32:0] r_num, r_den;
    logic [31:0]        num_mag, den_mag;
    logic               r_one;

    logic [FW-1:0] r_f, f_use;
    logic          r_fdiv;
    logic [31:0]   r_rem, r_dmag;
    logic [QW-1:0] r_quo;
    logic [32:0]   rem2;

    logic signed [31:0] a_sel, b_sel;
    logic signed [32:0] diff;
    logic signed [50:0] prod;
    logic signed [49:0] r_prod;
    logic signed [31:0] r_res_x, r_res_y, r_res_z, res;
    logic               r_out_valid;

    // Clamp key count to one..MAX_KEYS
    always_comb begin
        if (i_key_count == 7'd0) begin
            n_keys = NW'(1);
        end else if (int'(i_key_count) > MAX_KEYS) begin
            n_keys = NW'(MAX_KEYS);
        end else begin
            n_keys = NW'(i_key_count);
        end
    end

    assign wr_ok   = int'(i_key_index) < MAX_KEYS;
    assign wr_addr = AW'(i_key_index);

    // Read address select
    always_comb begin
        case (i_cmd.addr_sel)
            kvl_pkg::ADDR_SCAN: rd_addr = r_k + 1'b1;
            kvl_pkg::ADDR_I:    rd_addr = r_i;
            kvl_pkg::ADDR_J:    rd_addr = r_i + 1'b1;
            default:            rd_addr = r_i;
        endcase
    end

    // Table write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we && wr_ok) begin
            mem_t[wr_addr] <= i_key_time;
            mem_x[wr_addr] <= i_key_x;
            mem_y[wr_addr] <= i_key_y;
            mem_z[wr_addr] <= i_key_z;
        end
        r_rd_t <= mem_t[rd_addr];
        r_rd_x <= mem_x[rd_addr];
        r_rd_y <= mem_y[rd_addr];
        r_rd_z <= mem_z[rd_addr];
    end

    // Scan status
    assign k_plus2          = (NW + 1)'(r_k) + (NW + 1)'(2);
    assign o_sts.one_key    = (n_keys == NW'(1));
    assign o_sts.scan_hit   = r_t < r_rd_t;
    assign o_sts.scan_last  = k_plus2 >= {1'b0, n_keys};

    // Magnitudes of distance and gap
    assign num_mag = r_num[32] ? 32'(-r_num) : r_num[31:0];
    assign den_mag = r_den[32] ? 32'(-r_den) : r_den[31:0];
    assign o_sts.need_div = !r_one && (r_den != '0) && (r_num != '0)
                            && (r_num[32] == r_den[32]) && (num_mag < den_mag);

    assign rem2 = {r_rem, 1'b0};

    // Scan, key latches and divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_t   <= i_sample_time;
            r_k   <= '0;
            r_i   <= '0;
            r_one <= o_sts.one_key;
        end
        if (i_cmd.scan_step) begin
            r_k <= r_k + 1'b1;
        end
        if (i_cmd.take_i) begin
            r_i <= r_k;
        end
        if (i_cmd.lat_a) begin
            r_a_t <= r_rd_t;
            r_ax  <= r_rd_x;
            r_ay  <= r_rd_y;
            r_az  <= r_rd_z;
        end
        // With one key the end key repeats the start key
        if (i_cmd.lat_b) begin
            r_bx  <= r_one ? r_ax : r_rd_x;
            r_by  <= r_one ? r_ay : r_rd_y;
            r_bz  <= r_one ? r_az : r_rd_z;
            r_num <= $signed({1'b0, r_t}) - $signed({1'b0, r_a_t});
            r_den <= $signed({1'b0, r_rd_t}) - $signed({1'b0, r_a_t});
        end
        if (i_cmd.f_set) begin
            r_fdiv <= o_sts.need_div;
            r_rem  <= num_mag;
            r_dmag <= den_mag;
            r_quo  <= '0;
            if (r_one || (r_den != '0 && (r_num == '0 || r_num[32] != r_den[32]))) begin
                r_f <= kvl_pkg::F_ZERO;
            end else begin
                r_f <= kvl_pkg::F_ONE;
            end
        end
        // One restoring quotient bit
        if (i_cmd.div_step) begin
            if (rem2 >= {1'b0, r_dmag}) begin
                r_rem <= 32'(rem2 - {1'b0, r_dmag});
                r_quo <= {r_quo[QW-2:0], 1'b1};
            end else begin
                r_rem <= rem2[31:0];
                r_quo <= {r_quo[QW-2:0], 1'b0};
            end
        end
    end

    // Component select for the shared multiplier
    always_comb begin
        case (i_cmd.comp)
            kvl_pkg::COMP_X: begin a_sel = r_ax; b_sel = r_bx; end
            kvl_pkg::COMP_Y: begin a_sel = r_ay; b_sel = r_by; end
            kvl_pkg::COMP_Z: begin a_sel = r_az; b_sel = r_bz; end
            default:         begin a_sel = r_ax; b_sel = r_bx; end
        endcase
    end

    assign f_use = r_fdiv ? {1'b0, r_quo} : r_f;
    assign diff  = 33'(b_sel) - 33'(a_sel);
    assign prod  = diff * $signed({1'b0, f_use});
    // Floor of product scaled by 2^-16, added to start
    assign res   = a_sel + r_prod[47:16];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= prod[49:0];
        end
        if (i_cmd.acc) begin
            case (i_cmd.comp)
                kvl_pkg::COMP_X: r_res_x <= res;
                kvl_pkg::COMP_Y: r_res_y <= res;
                default:         r_res_z <= res;
            endcase
        end
        if (i_cmd.out_load) begin
            o_out_x <= r_res_x;
            o_out_y <= r_res_y;
            o_out_z <= r_res_z;
        end
    end

    // Output item valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

endmodule

### rtl/keyframe_vec3_lerp_core.sv
// Top level of the keyframe vec3 interpolation core with its APB register.
// Depends on kvl_pkg, kvl_ctrl and kvl_dpath.
//
// A load item (func 0) writes one keyframe; the core is ready again in the
// next cycle. For a sample item the result becomes valid after the scan, the
// fetch of both keys, the division and a multiply and add for each of x, y
// and z, plus any wait for the output register; the divider is skipped when
// the factor is zero or one. The core accepts the next item in the same cycle
// that the result becomes valid. The linear scan visits no key with one key,
// else up to the clamped key count minus one, before it finds the segment: it
// reads one table entry at a time through the single read port of the key
// tables, the factor comes from a 16-step restoring divider, and one shared
// multiplier serves x, y and z in turn. A finished result waits in the output
// register while the next item is accepted.
module keyframe_vec3_lerp_core #(
    parameter int MAX_KEYS = kvl_pkg::DEF_MAX_KEYS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_func,
    input  logic [5:0]         i_key_index,
    input  logic [31:0]        i_key_time,
    input  logic signed [31:0] i_key_x,
    input  logic signed [31:0] i_key_y,
    input  logic signed [31:0] i_key_z,
    input  logic [31:0]        i_sample_time,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    kvl_pkg::t_kvl_cmd cmd;
    kvl_pkg::t_kvl_sts sts;
    logic [6:0]        r_key_count;

    // Configuration register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= 7'd1;
        end else if (psel && penable && pwrite && paddr[2] == kvl_pkg::REG_KEY_COUNT) begin
            r_key_count <= pwdata[6:0];
        end
    end
    assign prdata = (paddr[2] == kvl_pkg::REG_KEY_COUNT) ? {25'd0, r_key_count} : 32'd0;

    kvl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    kvl_dpath #(
        .MAX_KEYS (MAX_KEYS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_key_count   (r_key_count),
        .i_key_index   (i_key_index),
        .i_key_time    (i_key_time),
        .i_key_x       (i_key_x),
        .i_key_y       (i_key_y),
        .i_key_z       (i_key_z),
        .i_sample_time (i_sample_time),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z)
    );

    // A sample item keeps the input side stalled while it is worked on
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_func == kvl_pkg::FUNC_SAMPLE) |=> o_in_stall)
        else $error("input not stalled after sample item");

    // A load item leaves the core ready in the next cycle
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_func == kvl_pkg::FUNC_LOAD) |=> !o_in_stall)
        else $error("input stalled after load item");

    // A new result appears only at the end of a sample in progress
    a_out_from_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without sample item");

endmodule
